>>> rtl/line_row_crossing_finder_defines.svh
// Assertion macros for the line row crossing finder checker.
// Needs signals named clock and reset in the scope of use.
`ifndef LINE_ROW_CROSSING_FINDER_DEFINES_SVH
`define LINE_ROW_CROSSING_FINDER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define LRCF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define LRCF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define LRCF_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lrcf_pkg.sv
// Shared constants and controller/datapath signal groups for the
// line row crossing finder. No dependencies.
`default_nettype none

package lrcf_pkg;

   localparam int COORD_WIDTH_DEFAULT = 12;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture the request
      logic setup;   // deltas, directions, span, step count
      logic step;    // one DDA step
      logic finish;  // write the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic match;     // current row equals target row
      logic last;      // no steps left after this check
      logic out_busy;  // result register still occupied
   } status_type;

endpackage

`default_nettype wire

>>> rtl/lrcf_if.sv
// Request and response channel interfaces (valid/ready with payload).
// Widths follow COORD_WIDTH, defaulting from lrcf_pkg.
`default_nettype none

interface lrcf_req_if #(parameter int COORD_WIDTH = lrcf_pkg::COORD_WIDTH_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic signed [COORD_WIDTH-1:0] target_row;

   modport source (output valid, start_x, start_y, end_x, end_y, target_row,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, target_row,
                 output ready);
endinterface

interface lrcf_rsp_if #(parameter int COORD_WIDTH = lrcf_pkg::COORD_WIDTH_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] crossing_x;
   logic                          found;

   modport source (output valid, crossing_x, found, input ready);
   modport sink (input valid, crossing_x, found, output ready);
endinterface

`default_nettype wire

>>> rtl/lrcf_ctrl.sv
// Sequencing FSM for the line row crossing finder.
// Uses lrcf_pkg command and status groups.
`default_nettype none

module lrcf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lrcf_pkg::status_type  status,
   output lrcf_pkg::cmd_type          cmd
);
   import lrcf_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SETUP,
      WALK,
      HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      done;

   assign done = status.match || status.last;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = SETUP;
            end
         end
         SETUP: begin
            cmd.setup = 1'b1;
            state_in  = WALK;
         end
         WALK: begin
            if (done) begin
               if (!status.out_busy) begin
                  cmd.finish = 1'b1;
                  state_in   = IDLE;
               end else begin
                  state_in = HOLD;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         HOLD: begin
            // walk is frozen, so match/last are still those of the final check
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lrcf_datapath.sv
// DDA walk datapath and result register for the line row crossing finder.
// Uses lrcf_pkg command and status groups.
`default_nettype none

module lrcf_datapath #(
   parameter int COORD_WIDTH = lrcf_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [COORD_WIDTH-1:0] start_x,
   input  wire logic signed [COORD_WIDTH-1:0] start_y,
   input  wire logic signed [COORD_WIDTH-1:0] end_x,
   input  wire logic signed [COORD_WIDTH-1:0] end_y,
   input  wire logic signed [COORD_WIDTH-1:0] target_row,
   input  wire lrcf_pkg::cmd_type             cmd,
   output lrcf_pkg::status_type               status,
   output logic signed [COORD_WIDTH-1:0]      crossing_x,
   output logic                               found,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready
);
   import lrcf_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam logic [W-1:0] ONE   = W'(1);
   localparam logic [W:0]   ONE_X = (W+1)'(1);

   logic signed [W-1:0] col_ff, row_ff, goal_ff, ex_ff, ey_ff;
   logic [W-1:0]        dx_ff, dy_ff, span_ff;
   logic [W:0]          accx_ff, accy_ff;
   logic [W:0]          cnt_ff;
   logic                negx_ff, negy_ff;
   logic                out_valid_ff;
   logic signed [W-1:0] out_x_ff;
   logic                out_found_ff;

   logic [W:0]   diffx, diffy, magx, magy;
   logic [W-1:0] span_in;
   logic [W:0]   sumx, sumy;
   logic         movex, movey;

   // setup: signed differences in W+1 bits, magnitudes fit in W bits
   assign diffx = {ex_ff[W-1], ex_ff} - {col_ff[W-1], col_ff};
   assign diffy = {ey_ff[W-1], ey_ff} - {row_ff[W-1], row_ff};
   assign magx  = diffx[W] ? (~diffx + ONE_X) : diffx;
   assign magy  = diffy[W] ? (~diffy + ONE_X) : diffy;
   assign span_in = (magx[W-1:0] > magy[W-1:0]) ? magx[W-1:0] : magy[W-1:0];

   // walk: an accumulator moves its axis when it strictly passes the span
   assign sumx  = accx_ff + {1'b0, dx_ff};
   assign sumy  = accy_ff + {1'b0, dy_ff};
   assign movex = sumx > {1'b0, span_ff};
   assign movey = sumy > {1'b0, span_ff};

   assign status.match    = (row_ff == goal_ff);
   assign status.last     = (cnt_ff == '0);
   assign status.out_busy = out_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff  <= start_x;
         row_ff  <= start_y;
         ex_ff   <= end_x;
         ey_ff   <= end_y;
         goal_ff <= target_row;
         accx_ff <= '0;
         accy_ff <= '0;
      end
      if (cmd.setup) begin
         dx_ff   <= magx[W-1:0];
         dy_ff   <= magy[W-1:0];
         negx_ff <= diffx[W];
         negy_ff <= diffy[W];
         span_ff <= span_in;
         cnt_ff  <= {1'b0, span_in} + ONE_X;
      end
      if (cmd.step) begin
         cnt_ff  <= cnt_ff - ONE_X;
         accx_ff <= movex ? (sumx - {1'b0, span_ff}) : sumx;
         accy_ff <= movey ? (sumy - {1'b0, span_ff}) : sumy;
         if (movex) begin
            col_ff <= negx_ff ? (col_ff - ONE) : (col_ff + ONE);
         end
         if (movey) begin
            row_ff <= negy_ff ? (row_ff - ONE) : (row_ff + ONE);
         end
      end
      if (cmd.finish) begin
         out_x_ff     <= status.match ? col_ff : '0;
         out_found_ff <= status.match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign crossing_x = out_x_ff;
   assign found      = out_found_ff;

endmodule

`default_nettype wire

>>> rtl/line_row_crossing_finder.sv
// Line row crossing finder: integer DDA walk of a segment, reporting the
// column at which it first reaches a target row.
//
// Usage:
//   req_bus (sink) carries start_x, start_y, end_x, end_y, target_row; a
//   request is taken when valid and ready are high at a rising edge.
//   rsp_bus (source) carries crossing_x and found, one response per request.
//   found = 0 means the row was never reached, crossing_x is then zero.
// Sequencing (span = max(|end_x - start_x|, |end_y - start_y|)):
//   a setup state, then a walk state that checks the row before each DDA
//   step, at most span + 2 checks; the result register is written when the
//   row matches or no steps are left. Each request occupies the walk until
//   it ends, so the next request is only taken after that, as the datapath
//   has a single step unit.
// Stalls: the response sits in an output register; the next request is
//   taken while it waits, and the walk only holds at its end if the
//   register is still full.
// Reset: synchronous, active high; clears the controller and response valid.
// Depends on lrcf_pkg, lrcf_if, lrcf_ctrl, lrcf_datapath.
`default_nettype none

module line_row_crossing_finder #(
   parameter int COORD_WIDTH = lrcf_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lrcf_req_if.sink   req_bus,
   lrcf_rsp_if.source rsp_bus
);
   import lrcf_pkg::*;

   cmd_type    cmd;
   status_type status;

   lrcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrcf_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .start_x    (req_bus.start_x),
      .start_y    (req_bus.start_y),
      .end_x      (req_bus.end_x),
      .end_y      (req_bus.end_y),
      .target_row (req_bus.target_row),
      .cmd        (cmd),
      .status     (status),
      .crossing_x (rsp_bus.crossing_x),
      .found      (rsp_bus.found),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready)
   );

endmodule

`default_nettype wire

>>> rtl/lrcf_checker.sv
// Port-level assertions for line_row_crossing_finder, with its bind.
// Depends on line_row_crossing_finder_defines.svh.
`default_nettype none

`include "line_row_crossing_finder_defines.svh"

module lrcf_checker #(
   parameter int COORD_WIDTH = lrcf_pkg::COORD_WIDTH_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic signed [COORD_WIDTH-1:0] crossing_x,
   input wire logic                          found
);

   `LRCF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `LRCF_ASSERT_IMPL(a_miss_zero, rsp_valid && !found, crossing_x == '0, "miss with nonzero column")
   `LRCF_ASSERT_NEXT(a_min_latency, req_valid && req_ready && !rsp_valid, !rsp_valid, "response too early")
   `LRCF_ASSERT_NEXT_ALWAYS(a_reset_clear, reset, !rsp_valid, "response valid after reset")

endmodule

bind line_row_crossing_finder lrcf_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_lrcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .crossing_x (rsp_bus.crossing_x),
   .found      (rsp_bus.found)
);

`default_nettype wire

>>> test/line_row_crossing_finder_test.sv
// Self-checking bench for line_row_crossing_finder: random and directed segments,
// predicted crossings compared per response. Needs lrcf_pkg, lrcf_if and the RTL.
`default_nettype none

module line_row_crossing_finder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W              = lrcf_pkg::COORD_WIDTH_DEFAULT;
   localparam int COORD_MIN      = -(1 << (W - 1));
   localparam int COORD_MAX      = (1 << (W - 1)) - 1;
   localparam int RANDOM_SEGS    = 120;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int QUIET_LIMIT    = 20000;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct {
      logic signed [W-1:0] start_x;
      logic signed [W-1:0] start_y;
      logic signed [W-1:0] end_x;
      logic signed [W-1:0] end_y;
      logic signed [W-1:0] target_row;
   } segment_type;

   typedef struct {
      logic signed [W-1:0] crossing_x;
      logic                found;
   } crossing_type;

   logic clock;
   logic reset;

   lrcf_req_if #(.COORD_WIDTH(W)) req_bus ();
   lrcf_rsp_if #(.COORD_WIDTH(W)) rsp_bus ();

   line_row_crossing_finder #(.COORD_WIDTH(W)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   segment_type  pending_segs[$];
   crossing_type expected_crossings[$];
   int           errors;
   int           crossings_found;
   int           rows_missed;
   int           responses_checked;
   int           total_requests;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic segment_type make_seg(int sx, int sy, int ex, int ey, int row);
      segment_type s;
      s.start_x    = W'(sx);
      s.start_y    = W'(sy);
      s.end_x      = W'(ex);
      s.end_y      = W'(ey);
      s.target_row = W'(row);
      return s;
   endfunction

   function automatic int fit_coord(int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Integer DDA walk: span+2 steps, row checked before each advance.
   function automatic crossing_type predict_crossing(segment_type s);
      int col, row, goal, dx, dy, dir_x, dir_y, span, err_x, err_y;
      crossing_type r;
      col   = s.start_x;
      row   = s.start_y;
      goal  = s.target_row;
      dx    = int'(s.end_x) - col;
      dy    = int'(s.end_y) - row;
      dir_x = 0;
      dir_y = 0;
      if (dx > 0) dir_x = 1;
      else if (dx < 0) begin
         dir_x = -1;
         dx    = -dx;
      end
      if (dy > 0) dir_y = 1;
      else if (dy < 0) begin
         dir_y = -1;
         dy    = -dy;
      end
      span  = (dx > dy) ? dx : dy;
      err_x = 0;
      err_y = 0;
      r.found      = 1'b0;
      r.crossing_x = '0;
      for (int k = 0; k <= span + 1; k++) begin
         if (row == goal) begin
            r.found      = 1'b1;
            r.crossing_x = W'(col);
            return r;
         end
         err_x += dx;
         err_y += dy;
         if (err_x > span) begin
            err_x -= span;
            col   += dir_x;
         end
         if (err_y > span) begin
            err_y -= span;
            row   += dir_y;
         end
      end
      return r;
   endfunction

   // Mostly short segments with the target row inside their height; some long ones,
   // some with the target just off either end, and some fully random.
   function automatic segment_type random_segment();
      int mode, sx, sy, ex, ey, row, reach, lo, hi;
      mode = $urandom_range(99, 0);
      sx   = $urandom_range(4095, 0) - 2048;
      sy   = $urandom_range(4095, 0) - 2048;
      if (mode < 15) begin
         ex  = $urandom_range(4095, 0) - 2048;
         ey  = $urandom_range(4095, 0) - 2048;
         row = $urandom_range(4095, 0) - 2048;
      end else begin
         reach = (mode < 25) ? 400 : 24;
         ex    = fit_coord(sx + $urandom_range(2 * reach, 0) - reach);
         ey    = fit_coord(sy + $urandom_range(2 * reach, 0) - reach);
         lo    = (sy < ey) ? sy : ey;
         hi    = (sy < ey) ? ey : sy;
         if (mode < 88)
            row = lo + $urandom_range(hi - lo, 0);
         else if (mode[0])
            row = fit_coord(hi + $urandom_range(3, 1));
         else
            row = fit_coord(lo - $urandom_range(3, 1));
      end
      return make_seg(sx, sy, ex, ey, row);
   endfunction

   // Request driver; expectations are queued as each request is taken.
   always @(posedge clock) begin : drive_requests
      segment_type seg;
      bit          idle;
      static int   requests_sent = 0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seg.start_x    = req_bus.start_x;
            seg.start_y    = req_bus.start_y;
            seg.end_x      = req_bus.end_x;
            seg.end_y      = req_bus.end_y;
            seg.target_row = req_bus.target_row;
            expected_crossings.push_back(predict_crossing(seg));
            requests_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            idle = !(requests_sent >= 60 && requests_sent < 95) &&
                   ($urandom_range(99, 0) < 22);
            if (pending_segs.size() != 0 && !idle) begin
               seg = pending_segs.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.start_x    <= seg.start_x;
               req_bus.start_y    <= seg.start_y;
               req_bus.end_x      <= seg.end_x;
               req_bus.end_y      <= seg.end_y;
               req_bus.target_row <= seg.target_row;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with one long hold-off to back the block up.
   always @(posedge clock) begin : drive_ready
      bit        stall;
      static int responses_taken = 0;
      static int holdoff_left    = 0;
      static bit holdoff_done    = 1'b0;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            responses_taken++;
         if (!holdoff_done && responses_taken >= 20) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            stall = 1'b1;
         end else begin
            stall = !(responses_taken >= 60 && responses_taken < 95) &&
                    ($urandom_range(99, 0) < 22);
         end
         rsp_bus.ready <= !stall;
      end
   end

   always @(posedge clock) begin : check_responses
      crossing_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_checked++;
         if (rsp_bus.found) crossings_found++;
         else rows_missed++;
         if (expected_crossings.size() == 0) begin
            $display("%0t: response with no request outstanding: crossing_x %0d found %0b",
                     $time, rsp_bus.crossing_x, rsp_bus.found);
            errors++;
         end else begin
            want = expected_crossings.pop_front();
            if (rsp_bus.found !== want.found) begin
               $display("%0t: found mismatch: expected %0b, got %0b",
                        $time, want.found, rsp_bus.found);
               errors++;
            end
            if (rsp_bus.crossing_x !== want.crossing_x) begin
               $display("%0t: crossing_x mismatch: expected %0d, got %0d",
                        $time, want.crossing_x, rsp_bus.crossing_x);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      static int quiet = 0;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, quiet);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.start_x    = '0;
      req_bus.start_y    = '0;
      req_bus.end_x      = '0;
      req_bus.end_y      = '0;
      req_bus.target_row = '0;
      rsp_bus.ready      = 1'b0;
      errors             = 0;
      crossings_found    = 0;
      rows_missed        = 0;
      responses_checked  = 0;

      // zero-length segment, on and off the row
      pending_segs.push_back(make_seg(5, 7, 5, 7, 7));
      pending_segs.push_back(make_seg(5, 7, 5, 7, 8));
      // horizontal and vertical
      pending_segs.push_back(make_seg(-10, 3, 20, 3, 3));
      pending_segs.push_back(make_seg(-10, 3, 20, 3, 4));
      pending_segs.push_back(make_seg(0, -5, 0, 5, 2));
      pending_segs.push_back(make_seg(0, 5, 0, -5, -3));
      // shallow, steep, diagonal, both directions negative
      pending_segs.push_back(make_seg(0, 0, 100, 7, 4));
      pending_segs.push_back(make_seg(0, 0, 7, 100, 50));
      pending_segs.push_back(make_seg(0, 0, 10, 10, 5));
      pending_segs.push_back(make_seg(100, 50, -30, -20, 0));
      // target on the end row, just past it, just before the start row, far off
      pending_segs.push_back(make_seg(3, 4, 50, 30, 30));
      pending_segs.push_back(make_seg(3, 4, 50, 30, 31));
      pending_segs.push_back(make_seg(3, 4, 50, 30, 3));
      pending_segs.push_back(make_seg(3, 4, 50, 30, COORD_MAX));
      // full-range corners
      pending_segs.push_back(make_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0));
      pending_segs.push_back(make_seg(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                      COORD_MIN));
      pending_segs.push_back(make_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                      COORD_MAX));
      pending_segs.push_back(make_seg(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, -1));
      pending_segs.push_back(make_seg(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MIN));
      pending_segs.push_back(make_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MAX));
      pending_segs.push_back(make_seg(COORD_MIN, 0, COORD_MAX, 1, 1));
      for (int i = 0; i < RANDOM_SEGS; i++)
         pending_segs.push_back(random_segment());
      total_requests = pending_segs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // every request must come back; the watchdog covers a hang
      while (responses_checked < total_requests) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d crossings found, %0d rows never reached,",
               responses_checked, crossings_found, rows_missed);
      $display("with random stalls on both sides and one %0d-cycle response hold-off.",
               HOLDOFF_CYCLES);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
